>>> sv/kpl_pkg.sv
// ----------------------------------------------------------------------------
// kpl_pkg: shared types and constants of the keypad password lock
// Item and result codes, operating modes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package kpl_pkg;

  localparam int MAX_ENTRY = 8;
  localparam int ENTRY_IDX_W = $clog2(MAX_ENTRY);

  // Operating modes of the lock.
  typedef enum logic [1:0] {
    MODE_ENTRY  = 2'd0,
    MODE_VERIFY = 2'd1,
    MODE_GRANT  = 2'd2,
    MODE_LOCKED = 2'd3
  } mode_t;

  // Request kinds on the input channel.
  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_PHONE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result kinds.
  typedef enum logic [2:0] {
    MSG_ECHO     = 3'd0,
    MSG_CORRECT  = 3'd1,
    MSG_WRONG    = 3'd2,
    MSG_LOCKED   = 3'd3,
    MSG_TIMEOUT  = 3'd4,
    MSG_PROMPT   = 3'd5,
    MSG_PHONE_OK = 3'd6,
    MSG_GRANTED  = 3'd7
  } msg_t;

  localparam logic [7:0] KEY_DELETE  = 8'h2A;  // '*'
  localparam logic [7:0] KEY_CONFIRM = 8'h23;  // '#'

  // Configuration register indexes.
  localparam logic [2:0] REG_PASSWORD_VALUE  = 3'd0;
  localparam logic [2:0] REG_PASSWORD_LENGTH = 3'd1;
  localparam logic [2:0] REG_TRY_LIMIT       = 3'd2;
  localparam logic [2:0] REG_LOCK_TICKS      = 3'd3;
  localparam logic [2:0] REG_AUTH_TICKS      = 3'd4;
  localparam logic [2:0] REG_GRANT_TICKS     = 3'd5;

  // Reset values; the password is "1234567".
  localparam logic [63:0] RST_PASSWORD_VALUE  = 64'd15540725856023089;
  localparam logic [3:0]  RST_PASSWORD_LENGTH = 4'd7;
  localparam logic [3:0]  RST_TRY_LIMIT       = 4'd3;
  localparam logic [15:0] RST_LOCK_TICKS      = 16'd60;
  localparam logic [15:0] RST_AUTH_TICKS      = 16'd60;
  localparam logic [15:0] RST_GRANT_TICKS     = 16'd60;

  localparam logic [3:0] WRONG_MAX = 4'd15;

  typedef struct packed {
    msg_t        kind;
    logic [15:0] value;
    logic [3:0]  entry_length;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

>>> sv/keypad_password_lock_core.sv
// ----------------------------------------------------------------------------
// keypad_password_lock_core: keypad lock with phone verification and lockout
// Entry buffer, password check, attempt counting and tick-driven timeouts.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in_valid/in_ready channel as a command (key
// press, phone call or update tick) and a key code. Each request is acted on
// in the cycle it is accepted: the mode, entry buffer and counters update at
// that edge and the zero, one or two results it causes are written into a
// four-entry result queue. Results leave on out_valid/out_ready, one per
// cycle while the receiver is ready, and are registered in the queue before
// they appear. A request is taken whenever the queue holds two results or
// fewer, so while the receiver is ready a request that gives at most one
// result goes through every cycle, and the two results of a request leave
// one after the other. When the receiver stalls the queue fills and in_ready
// drops until room for two results is free again. The configuration port
// writes one register per cycle with cfg_write, cfg_index and cfg_data, and
// is meant to be used while the block is idle. Reset returns the lock to
// entry mode with an empty entry, clears the counters and the queue, and
// restores the default password and timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_password_lock_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  key_code,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       msg_kind,
  output logic [15:0]      value,
  output logic [3:0]       entry_length,
  output logic             last
);

  // Configuration registers.
  logic [63:0] password_value;
  logic [3:0]  password_length;
  logic [3:0]  try_limit;
  logic [15:0] lock_ticks;
  logic [15:0] auth_ticks;
  logic [15:0] grant_ticks;

  // Lock state.
  kpl_pkg::mode_t mode, mode_next;
  logic [7:0]  entry_chars [kpl_pkg::MAX_ENTRY];
  logic [3:0]  entry_count, entry_count_next;
  logic        entry_overflow, entry_overflow_next;
  logic [3:0]  wrong_count, wrong_count_next;
  logic [15:0] countdown, countdown_next;
  logic        grant_announced, grant_announced_next;

  // Result queue.
  kpl_pkg::result_t queue [4];
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] queue_count;

  logic in_accept, out_accept;
  logic is_key, is_phone, is_tick;
  logic key_delete, key_confirm, key_append;
  logic entry_match;
  logic [kpl_pkg::MAX_ENTRY-1:0] char_ok;
  logic [3:0]  wrong_inc;
  logic        limit_hit;
  logic [15:0] countdown_dec;
  logic        expired;
  logic        char_write;

  kpl_pkg::result_t res0, res1;
  logic [1:0] res_count;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      password_value  <= kpl_pkg::RST_PASSWORD_VALUE;
      password_length <= kpl_pkg::RST_PASSWORD_LENGTH;
      try_limit       <= kpl_pkg::RST_TRY_LIMIT;
      lock_ticks      <= kpl_pkg::RST_LOCK_TICKS;
      auth_ticks      <= kpl_pkg::RST_AUTH_TICKS;
      grant_ticks     <= kpl_pkg::RST_GRANT_TICKS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kpl_pkg::REG_PASSWORD_VALUE:  password_value  <= cfg_data;
        kpl_pkg::REG_PASSWORD_LENGTH: password_length <= cfg_data[3:0];
        kpl_pkg::REG_TRY_LIMIT:       try_limit       <= cfg_data[3:0];
        kpl_pkg::REG_LOCK_TICKS:      lock_ticks      <= cfg_data[15:0];
        kpl_pkg::REG_AUTH_TICKS:      auth_ticks      <= cfg_data[15:0];
        kpl_pkg::REG_GRANT_TICKS:     grant_ticks     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request decode and shared conditions
  // --------------------------------------------------------------------------
  assign in_ready   = (queue_count <= 3'd2);
  assign in_accept  = in_valid && in_ready;
  assign out_valid  = (queue_count != 3'd0);
  assign out_accept = out_valid && out_ready;

  // Keys only count in entry mode and a phone call only during verification.
  assign is_key   = (cmd == kpl_pkg::CMD_KEY) && (mode == kpl_pkg::MODE_ENTRY);
  assign is_phone = (cmd == kpl_pkg::CMD_PHONE) && (mode == kpl_pkg::MODE_VERIFY);
  assign is_tick  = (cmd == kpl_pkg::CMD_TICK);

  assign key_delete  = is_key && (key_code == kpl_pkg::KEY_DELETE);
  assign key_confirm = is_key && (key_code == kpl_pkg::KEY_CONFIRM);
  assign key_append  = is_key && !key_delete && !key_confirm;

  // Every stored character below the fill level must equal its password byte.
  always_comb begin
    for (int i = 0; i < kpl_pkg::MAX_ENTRY; i++) begin
      char_ok[i] = (4'(i) >= entry_count) ||
                   (entry_chars[i] == password_value[8*i +: 8]);
    end
  end

  assign entry_match = !entry_overflow && (entry_count == password_length) &&
                       (&char_ok);

  assign wrong_inc = (wrong_count < kpl_pkg::WRONG_MAX) ? wrong_count + 4'd1
                                                        : wrong_count;
  assign limit_hit = (wrong_inc >= try_limit);

  assign countdown_dec = (countdown != 16'd0) ? countdown - 16'd1 : 16'd0;
  assign expired       = (countdown_dec == 16'd0);

  assign char_write = key_append && (entry_count < 4'(kpl_pkg::MAX_ENTRY));

  // --------------------------------------------------------------------------
  // Mode transitions
  // --------------------------------------------------------------------------
  always_comb begin
    mode_next = mode;
    unique case (mode)
      kpl_pkg::MODE_ENTRY: begin
        if (key_confirm) begin
          if (entry_match) begin
            mode_next = kpl_pkg::MODE_VERIFY;
          end else if (limit_hit) begin
            mode_next = kpl_pkg::MODE_LOCKED;
          end
        end
      end
      kpl_pkg::MODE_VERIFY: begin
        if (is_phone) begin
          mode_next = kpl_pkg::MODE_GRANT;
        end else if (is_tick && expired) begin
          mode_next = kpl_pkg::MODE_ENTRY;
        end
      end
      kpl_pkg::MODE_GRANT,
      kpl_pkg::MODE_LOCKED: begin
        if (is_tick && expired) begin
          mode_next = kpl_pkg::MODE_ENTRY;
        end
      end
      default: mode_next = kpl_pkg::MODE_ENTRY;
    endcase
  end

  // --------------------------------------------------------------------------
  // Counters, entry buffer control and results
  // --------------------------------------------------------------------------
  always_comb begin
    entry_count_next     = entry_count;
    entry_overflow_next  = entry_overflow;
    wrong_count_next     = wrong_count;
    countdown_next       = countdown;
    grant_announced_next = grant_announced;
    res0      = '{kind: kpl_pkg::MSG_ECHO, value: 16'd0, entry_length: 4'd0, last: 1'b0};
    res1      = res0;
    res_count = 2'd0;

    if (is_key) begin
      if (key_delete) begin
        if (entry_overflow) begin
          entry_overflow_next = 1'b0;
        end else if (entry_count != 4'd0) begin
          entry_count_next = entry_count - 4'd1;
        end
        res_count = 2'd1;
      end else if (key_confirm) begin
        if (entry_match) begin
          res0.kind           = kpl_pkg::MSG_CORRECT;
          countdown_next      = auth_ticks;
          entry_count_next    = 4'd0;
          entry_overflow_next = 1'b0;
          wrong_count_next    = 4'd0;
        end else if (limit_hit) begin
          // The entry is kept until the lock expires.
          res0.kind        = kpl_pkg::MSG_LOCKED;
          res0.value       = lock_ticks;
          countdown_next   = lock_ticks;
          wrong_count_next = wrong_inc;
        end else begin
          res0.kind           = kpl_pkg::MSG_WRONG;
          res0.value          = {12'd0, try_limit - wrong_inc};
          wrong_count_next    = wrong_inc;
          entry_count_next    = 4'd0;
          entry_overflow_next = 1'b0;
        end
        res1.kind = kpl_pkg::MSG_ECHO;
        res_count = 2'd2;
      end else begin
        if (char_write) begin
          entry_count_next = entry_count + 4'd1;
        end else begin
          entry_overflow_next = 1'b1;
        end
        res_count = 2'd1;
      end
    end else if (is_phone) begin
      res0.kind            = kpl_pkg::MSG_PHONE_OK;
      countdown_next       = grant_ticks;
      grant_announced_next = 1'b0;
      res_count            = 2'd1;
    end else if (is_tick) begin
      unique case (mode)
        kpl_pkg::MODE_VERIFY: begin
          countdown_next = countdown_dec;
          if (expired) begin
            res0.kind = kpl_pkg::MSG_TIMEOUT;
            res1.kind = kpl_pkg::MSG_PROMPT;
            res_count = 2'd2;
          end
        end
        kpl_pkg::MODE_GRANT: begin
          countdown_next = countdown_dec;
          if (!grant_announced) begin
            grant_announced_next = 1'b1;
            res0.kind = kpl_pkg::MSG_GRANTED;
            res1.kind = kpl_pkg::MSG_PROMPT;
            res_count = expired ? 2'd2 : 2'd1;
          end else if (expired) begin
            res0.kind = kpl_pkg::MSG_PROMPT;
            res_count = 2'd1;
          end
        end
        kpl_pkg::MODE_LOCKED: begin
          countdown_next = countdown_dec;
          if (expired) begin
            res0.kind = kpl_pkg::MSG_PROMPT;
          end else begin
            res0.kind  = kpl_pkg::MSG_LOCKED;
            res0.value = countdown_dec;
          end
          res_count = 2'd1;
        end
        default: ;
      endcase
      // Expiry in any timed mode drops back to a clean entry state.
      if (mode != kpl_pkg::MODE_ENTRY && expired) begin
        entry_count_next    = 4'd0;
        entry_overflow_next = 1'b0;
        wrong_count_next    = 4'd0;
        countdown_next      = 16'd0;
      end
    end

    res0.entry_length = entry_count_next;
    res1.entry_length = entry_count_next;
    res0.last         = (res_count == 2'd1);
    res1.last         = 1'b1;
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= kpl_pkg::MODE_ENTRY;
      entry_count     <= 4'd0;
      entry_overflow  <= 1'b0;
      wrong_count     <= 4'd0;
      countdown       <= 16'd0;
      grant_announced <= 1'b0;
    end else if (in_accept) begin
      mode            <= mode_next;
      entry_count     <= entry_count_next;
      entry_overflow  <= entry_overflow_next;
      wrong_count     <= wrong_count_next;
      countdown       <= countdown_next;
      grant_announced <= grant_announced_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && char_write) begin
      entry_chars[entry_count[kpl_pkg::ENTRY_IDX_W-1:0]] <= key_code;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (res_count != 2'd0) begin
        queue[wr_ptr] <= res0;
      end
      if (res_count == 2'd2) begin
        queue[wr_ptr + 2'd1] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr      <= 2'd0;
      wr_ptr      <= 2'd0;
      queue_count <= 3'd0;
    end else begin
      if (in_accept) begin
        wr_ptr <= wr_ptr + res_count;
      end
      if (out_accept) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      queue_count <= queue_count + (in_accept ? {1'b0, res_count} : 3'd0)
                     - {2'd0, out_accept};
    end
  end

  assign msg_kind     = queue[rd_ptr].kind;
  assign value        = queue[rd_ptr].value;
  assign entry_length = queue[rd_ptr].entry_length;
  assign last         = queue[rd_ptr].last;

endmodule

`default_nettype wire
